@@ rtl/dwhr_pkg.sv @@
// shared types and codes for the half-rotate deque
`timescale 1ns / 1ps

package dwhr_pkg;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;
  localparam int DATA_W   = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SWAP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-request result information that travels beside the ram read
  typedef struct packed {
    logic                popped;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
  } res_info_t;

endpackage

@@ rtl/dwhr_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module dwhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/dwhr_ctrl.sv @@
// front pointer and word count, ram access decode per request
`timescale 1ns / 1ps

module dwhr_ctrl
  import dwhr_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [OPCODE_W-1:0]         opcode,
  output logic                        wen,
  output logic [$clog2(CAPACITY)-1:0] waddr,
  output logic                        ren,
  output logic [$clog2(CAPACITY)-1:0] raddr,
  output res_info_t                   info
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0] front;
  logic [PW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [SW-1:0] front_ext;
  logic [SW-1:0] count_ext;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] front_inc;
  logic [PW-1:0] back_pos;
  logic [PW-1:0] last_pos;
  logic [PW-1:0] mid_pos;
  logic          full;
  logic          empty;

  // sums stay below twice the capacity, so one subtract wraps them
  function automatic logic [PW-1:0] wrap_pos(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
    return r[PW-1:0];
  endfunction

  always_comb begin
    front_ext = SW'(front);
    count_ext = SW'(count);
    front_dec = (front == '0) ? PW'(CAPACITY - 1) : front - PW'(1);
    front_inc = wrap_pos(front_ext + SW'(1));
    back_pos  = wrap_pos(front_ext + count_ext);
    last_pos  = wrap_pos(front_ext + count_ext - SW'(1));
    mid_pos   = wrap_pos(front_ext + (count_ext >> 1));
    full      = (count == CW'(CAPACITY));
    empty     = (count == '0);
  end

  always_comb begin
    front_next  = front;
    count_next  = count;
    wen         = 1'b0;
    waddr       = back_pos;
    ren         = 1'b0;
    raddr       = front;
    info.popped = 1'b0;
    info.status = ST_OK;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + CW'(1);
          wen        = accept;
          waddr      = front_dec;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          wen        = accept;
          waddr      = back_pos;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          front_next  = front_inc;
          count_next  = count - CW'(1);
          ren         = accept;
          raddr       = front;
          info.popped = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          count_next  = count - CW'(1);
          ren         = accept;
          raddr       = last_pos;
          info.popped = 1'b1;
        end
      end
      OP_SWAP: begin
        // middle word becomes the front
        if (count > CW'(1)) begin
          front_next = mid_pos;
        end
      end
      default: begin
      end
    endcase
    info.size = SIZE_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/deque_with_half_rotate.sv @@
// top level of the half-rotate deque
`timescale 1ns / 1ps

// Double-ended queue of signed words in a ring of CAPACITY entries. One
// request (push front, push back, pop front, pop back, swap halves) is taken
// every clock cycle unless a waiting result stalls the input; its result is
// presented in the cycle after acceptance and is held there until taken,
// while the next request is accepted in the same cycle as the result leaves.
// Results come from the registered read of the ring memory, which has one
// write and one read port. The ring needs no clearing after reset: only
// entries written by a push are ever read. Words are kept in WORD_BITS bits
// and popped words are sign-extended or truncated to 32 bits; size reports
// the low 11 bits of the word count.
module deque_with_half_rotate
  import dwhr_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic signed [DATA_W-1:0]   push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   pop_value,
  output logic [STATUS_W-1:0]        status,
  output logic [SIZE_W-1:0]          size
);

  localparam int PW = $clog2(CAPACITY);

  logic                 accept;
  logic                 wen;
  logic [PW-1:0]        waddr;
  logic                 ren;
  logic [PW-1:0]        raddr;
  res_info_t            info_next;
  res_info_t            info;
  logic [63:0]          push_ext;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata;
  logic [63:0]          pop_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  dwhr_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (opcode),
    .wen    (wen),
    .waddr  (waddr),
    .ren    (ren),
    .raddr  (raddr),
    .info   (info_next)
  );

  assign push_ext = 64'(push_value);
  assign wdata    = push_ext[WORD_BITS-1:0];

  // read data register stays put while a pop result waits, as no read is issued
  dwhr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info <= info_next;
    end
  end

  assign pop_ext   = 64'(signed'(rdata));
  assign pop_value = info.popped ? signed'(pop_ext[DATA_W-1:0]) : '0;
  assign status    = info.status;
  assign size      = info.size;

endmodule

@@ rtl/dwhr_checker.sv @@
// port-level checks for the half-rotate deque, bound to the top level
`timescale 1ns / 1ps

module dwhr_checker
  import dwhr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [OPCODE_W-1:0]      opcode,
  input logic signed [DATA_W-1:0] push_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] pop_value,
  input logic [STATUS_W-1:0]      status,
  input logic [SIZE_W-1:0]        size
);

  // a waiting result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status)
      && $stable(size))
    else $error("result changed while stalled");

  // no request can be lost: an empty output side always takes a request
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // every accepted request yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // an error result carries no popped word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pop_value == '0)
    else $error("error result with nonzero pop value");

  // pop on empty leaves an empty queue
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> size == '0)
    else $error("empty error with nonzero size");

endmodule

bind deque_with_half_rotate dwhr_checker u_dwhr_checker (.*);
